// ===== rtl/core/periodic_task_release_timer_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the periodic task release timer
// Shared concurrent-check shorthands, clocked on the rising edge and
// disabled while the synchronous reset is held low.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TASK_RELEASE_TIMER_UNIT_MACROS_SVH
`define PERIODIC_TASK_RELEASE_TIMER_UNIT_MACROS_SVH

// same-cycle implication
`define PTRT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ptrt check failed: same-cycle implication");

// next-cycle implication
`define PTRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ptrt check failed: next-cycle implication");

`endif

// ===== rtl/core/ptrt_pkg.sv =====
// ----------------------------------------------------------------------------
// ptrt_pkg
// Shared constants and types of the periodic task release timer.
// ----------------------------------------------------------------------------
package ptrt_pkg;

    localparam int NUM_TASKS   = 8;   // 1..8
    localparam int TASK_SLOTS  = 8;
    localparam int TASK_W      = 3;
    localparam int SEL_W       = TASK_W + 1;
    localparam int TICK_W      = 32;
    localparam int CFG_IDX_W   = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    localparam logic [TICK_W-1:0] STARTUP_COUNT = 32'd123;

    typedef struct packed {
        logic              periodic;
        logic              high;
        logic [TICK_W-1:0] period;
    } t_setting;

    typedef struct packed {
        logic [TICK_W-1:0] elapsed;
        logic              startup;
    } t_job;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_UPDATE,
        BK_MASK,
        BK_EMIT
    } t_back_state;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef struct packed {
        logic busy;
        logic pop;
    } t_back_status;

endpackage

// ===== rtl/core/periodic_task_release_timer_unit.sv =====
// ----------------------------------------------------------------------------
// periodic_task_release_timer_unit
// Time-triggered release timer for up to eight tasks; each tick request
// yields the indices of the tasks released on that scheduler pass.
// ----------------------------------------------------------------------------
//  channel   dir   handshake                      payload
//  tick      in    i_tick_valid / o_tick_stall    i_systick_value
//  release   out   o_res_valid / i_res_stall      o_task_index, o_init_release,
//                                                 o_last_release
//  config    in    i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
//  A pass walks the task countdowns one task per cycle through a single
//  subtract/compare unit, and releases then leave one per cycle unless
//  the output is stalled.
//  A two-entry queue lets tick requests be taken while a pass is running.
//  Synchronous active-low reset; no clearing pass, ready right after reset.
//  Output stall holds the release register and pauses the release sequence.
// ----------------------------------------------------------------------------
`include "periodic_task_release_timer_unit_macros.svh"

module periodic_task_release_timer_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_tick_valid,
    output logic                             o_tick_stall,
    input  logic [ptrt_pkg::TICK_W-1:0]      i_systick_value,
    output logic                             o_res_valid,
    input  logic                             i_res_stall,
    output logic [ptrt_pkg::TASK_W-1:0]      o_task_index,
    output logic                             o_init_release,
    output logic                             o_last_release,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ptrt_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  ptrt_pkg::t_setting               i_cfg_data
);

    ptrt_pkg::t_setting      r_setting [ptrt_pkg::TASK_SLOTS];
    ptrt_pkg::t_queue_status queue_status;
    ptrt_pkg::t_back_status  back_status;
    ptrt_pkg::t_job          front_job;
    ptrt_pkg::t_job          head_job;
    logic                    front_push;
    logic                    startup_pending;

    assign o_cfg_ready = 1'b1;

    // writes beyond the last task slot are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ptrt_pkg::TASK_SLOTS; k++) begin
                r_setting[k] <= '0;
            end
        end else if (i_cfg_valid && o_cfg_ready &&
                     i_cfg_index < ptrt_pkg::CFG_IDX_W'(ptrt_pkg::TASK_SLOTS)) begin
            r_setting[i_cfg_index[ptrt_pkg::TASK_W-1:0]] <= i_cfg_data;
        end
    end

    ptrt_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_tick_valid      (i_tick_valid),
        .i_systick_value   (i_systick_value),
        .i_queue_status    (queue_status),
        .o_tick_stall      (o_tick_stall),
        .o_push            (front_push),
        .o_job             (front_job),
        .o_startup_pending (startup_pending)
    );

    ptrt_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (front_push),
        .i_job    (front_job),
        .i_pop    (back_status.pop),
        .o_job    (head_job),
        .o_status (queue_status)
    );

    ptrt_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (!queue_status.empty),
        .i_job          (head_job),
        .i_setting      (r_setting),
        .i_res_stall    (i_res_stall),
        .o_status       (back_status),
        .o_res_valid    (o_res_valid),
        .o_task_index   (o_task_index),
        .o_init_release (o_init_release),
        .o_last_release (o_last_release)
    );

    `PTRT_ASSERT_IMPLY(a_busy_has_request, i_clk, i_rst_n, back_status.busy, !queue_status.empty)
    `PTRT_ASSERT_NEXT(a_push_fills_queue, i_clk, i_rst_n, front_push, !queue_status.empty)
    `PTRT_ASSERT_IMPLY(a_init_after_first, i_clk, i_rst_n, o_res_valid && o_init_release, !startup_pending)

endmodule

// ===== rtl/core/ptrt_front.sv =====
// ----------------------------------------------------------------------------
// ptrt_front
// Takes tick requests, forms the elapsed count and the start-up flag.
// ----------------------------------------------------------------------------
module ptrt_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_tick_valid,
    input  logic [ptrt_pkg::TICK_W-1:0]   i_systick_value,
    input  ptrt_pkg::t_queue_status       i_queue_status,
    output logic                          o_tick_stall,
    output logic                          o_push,
    output ptrt_pkg::t_job                o_job,
    output logic                          o_startup_pending
);

    logic [ptrt_pkg::TICK_W-1:0] r_prev_tick;
    logic                        r_startup;

    assign o_tick_stall      = i_queue_status.full;
    assign o_push            = i_tick_valid && !i_queue_status.full;
    assign o_job.elapsed     = i_systick_value - r_prev_tick;   // wraps mod 2^32
    assign o_job.startup     = r_startup;
    assign o_startup_pending = r_startup;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_tick <= '0;
            r_startup   <= 1'b1;
        end else if (o_push) begin
            r_prev_tick <= i_systick_value;
            r_startup   <= 1'b0;
        end
    end

endmodule

// ===== rtl/core/ptrt_queue.sv =====
// ----------------------------------------------------------------------------
// ptrt_queue
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
module ptrt_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  ptrt_pkg::t_job          i_job,
    input  logic                    i_pop,
    output ptrt_pkg::t_job          o_job,
    output ptrt_pkg::t_queue_status o_status
);

    ptrt_pkg::t_job                   r_data [ptrt_pkg::QUEUE_DEPTH];
    logic [ptrt_pkg::QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [ptrt_pkg::QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [ptrt_pkg::QUEUE_CNT_W-1:0] r_count;
    logic [ptrt_pkg::QUEUE_PTR_W-1:0] n_wr_ptr;
    logic [ptrt_pkg::QUEUE_PTR_W-1:0] n_rd_ptr;

    localparam logic [ptrt_pkg::QUEUE_PTR_W-1:0] LastPtr =
        ptrt_pkg::QUEUE_PTR_W'(ptrt_pkg::QUEUE_DEPTH - 1);

    assign o_job          = r_data[r_rd_ptr];
    assign o_status.full  = (r_count == ptrt_pkg::QUEUE_CNT_W'(ptrt_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);

    always_comb begin
        n_wr_ptr = (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
        n_rd_ptr = (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ===== rtl/core/ptrt_back.sv =====
// ----------------------------------------------------------------------------
// ptrt_back
// Countdown walker and release sequencer: one task per cycle through a shared
// subtract/compare, then one release per unstalled cycle to output register.
// ----------------------------------------------------------------------------
module ptrt_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_job_valid,
    input  ptrt_pkg::t_job                i_job,
    input  ptrt_pkg::t_setting            i_setting [ptrt_pkg::TASK_SLOTS],
    input  logic                          i_res_stall,
    output ptrt_pkg::t_back_status        o_status,
    output logic                          o_res_valid,
    output logic [ptrt_pkg::TASK_W-1:0]   o_task_index,
    output logic                          o_init_release,
    output logic                          o_last_release
);

    localparam int N = ptrt_pkg::NUM_TASKS;
    localparam logic [ptrt_pkg::TASK_W-1:0] LastIdx = ptrt_pkg::TASK_W'(N - 1);

    ptrt_pkg::t_back_state       r_state;
    ptrt_pkg::t_back_state       n_state;
    logic [ptrt_pkg::TASK_W-1:0] r_idx;
    logic [ptrt_pkg::TICK_W-1:0] r_cd [N];
    logic [N-1:0]                r_zero;
    logic [2*N-1:0]              r_mask;       // {normal, start-up}
    logic                        r_res_valid;
    logic [ptrt_pkg::TASK_W-1:0] r_task_index;
    logic                        r_init_release;
    logic                        r_last_release;

    logic                        pop;
    logic                        do_update;
    logic                        do_mask;
    logic                        do_emit;
    logic                        out_free;
    logic [ptrt_pkg::SEL_W-1:0]  sel;
    logic [2*N-1:0]              sel_onehot;
    logic                        emit_init;
    logic                        emit_last;
    logic [ptrt_pkg::TASK_W-1:0] sel_task;
    logic [ptrt_pkg::TASK_W-1:0] rd_idx;
    ptrt_pkg::t_setting          cur_set;
    logic [ptrt_pkg::TICK_W-1:0] cur_cd;
    logic [ptrt_pkg::TICK_W-1:0] dec_cd;
    logic [ptrt_pkg::TICK_W-1:0] upd_cd;
    logic [N-1:0]                start_mask;
    logic [2*N-1:0]              mask_next;

    assign out_free = !r_res_valid || !i_res_stall;

    // lowest pending release first: start-up releases sit in the low half
    always_comb begin
        sel = '0;
        for (int i = 2*N - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                sel = ptrt_pkg::SEL_W'(i);
            end
        end
        sel_onehot = (2*N)'(1) << sel;
        emit_last  = ((r_mask & ~sel_onehot) == '0);
        emit_init  = (sel < ptrt_pkg::SEL_W'(N));
        sel_task   = emit_init ? sel[ptrt_pkg::TASK_W-1:0]
                               : ptrt_pkg::TASK_W'(sel - ptrt_pkg::SEL_W'(N));
    end

    assign rd_idx  = (r_state == ptrt_pkg::BK_EMIT) ? sel_task : r_idx;
    assign cur_set = i_setting[rd_idx];
    assign cur_cd  = r_cd[r_idx];

    // count down, then force to zero when left above the period
    always_comb begin
        dec_cd = (cur_cd != '0) ? cur_cd - i_job.elapsed : cur_cd;
        upd_cd = (dec_cd > cur_set.period) ? '0 : dec_cd;
    end

    always_comb begin
        for (int k = 0; k < N; k++) begin
            start_mask[k] = i_job.startup && i_setting[k].high && r_zero[k];
        end
        mask_next = {r_zero & ~start_mask, start_mask};
    end

    always_comb begin
        n_state   = r_state;
        pop       = 1'b0;
        do_update = 1'b0;
        do_mask   = 1'b0;
        do_emit   = 1'b0;
        unique case (r_state)
            ptrt_pkg::BK_IDLE: begin
                if (i_job_valid) begin
                    n_state = ptrt_pkg::BK_UPDATE;
                end
            end
            ptrt_pkg::BK_UPDATE: begin
                do_update = 1'b1;
                if (r_idx == LastIdx) begin
                    n_state = ptrt_pkg::BK_MASK;
                end
            end
            ptrt_pkg::BK_MASK: begin
                do_mask = 1'b1;
                if (mask_next == '0) begin
                    pop     = 1'b1;
                    n_state = ptrt_pkg::BK_IDLE;
                end else begin
                    n_state = ptrt_pkg::BK_EMIT;
                end
            end
            ptrt_pkg::BK_EMIT: begin
                if (out_free) begin
                    do_emit = 1'b1;
                    if (emit_last) begin
                        pop     = 1'b1;
                        n_state = ptrt_pkg::BK_IDLE;
                    end
                end
            end
            default: begin
                n_state = ptrt_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ptrt_pkg::BK_IDLE;
            r_idx       <= '0;
            r_zero      <= '1;
            r_mask      <= '0;
            r_res_valid <= 1'b0;
            for (int k = 0; k < N; k++) begin
                r_cd[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == ptrt_pkg::BK_IDLE) begin
                r_idx <= '0;
            end else if (do_update) begin
                r_idx <= r_idx + 1'b1;
            end
            // high-priority tasks never count down
            if (do_update && !cur_set.high) begin
                r_cd[r_idx]   <= upd_cd;
                r_zero[r_idx] <= (upd_cd == '0);
            end
            if (do_mask) begin
                r_mask <= mask_next;
            end
            if (do_emit) begin
                r_mask <= r_mask & ~sel_onehot;
                if (emit_init) begin
                    r_cd[sel_task]   <= ptrt_pkg::STARTUP_COUNT;
                    r_zero[sel_task] <= 1'b0;
                end else if (cur_set.periodic) begin
                    r_cd[sel_task]   <= cur_set.period;
                    r_zero[sel_task] <= (cur_set.period == '0);
                end
            end
            if (do_emit) begin
                r_res_valid <= 1'b1;
            end else if (!i_res_stall) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_emit) begin
            r_task_index   <= sel_task;
            r_init_release <= emit_init;
            r_last_release <= emit_last;
        end
    end

    assign o_status.busy  = (r_state != ptrt_pkg::BK_IDLE);
    assign o_status.pop   = pop;
    assign o_res_valid    = r_res_valid;
    assign o_task_index   = r_task_index;
    assign o_init_release = r_init_release;
    assign o_last_release = r_last_release;

endmodule
